FILE: rtl/core/smac_pkg.sv
`timescale 1ns / 1ps

package smac_pkg;

    // Number of controlled axes and axis codes
    localparam int NUM_AXES = 3;
    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_BND  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd6;

    // Fixed register widths and reset values
    localparam int DT_BITS    = 16;
    localparam int DT_FRAC    = 16;
    localparam int INV_BITS   = 16;
    localparam int LIMIT_BITS = 31;
    localparam int DRIVE_BITS = 32;
    localparam logic [DT_BITS-1:0]    STEP_TIME_RST = 16'd655;
    localparam logic [INV_BITS-1:0]   INV_BND_RST   = 16'd256;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RST     = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // One multiply per step but the last; every step after the first also consumes the previous product
    typedef enum logic [2:0] {
        STEP_LAM_ERR,
        STEP_LAM_E,
        STEP_S_INVB,
        STEP_S_DT,
        STEP_KP_S,
        STEP_EPS_SW,
        STEP_KI_INT,
        STEP_FINAL
    } step_t;

    typedef struct packed {
        logic       load;
        logic       run;
        step_t      step;
        logic [1:0] axis;
        logic       out_load;
    } dp_cmd_t;

    function automatic step_t step_after(step_t s);
        step_t n;
        unique case (s)
            STEP_LAM_ERR: n = STEP_LAM_E;
            STEP_LAM_E:   n = STEP_S_INVB;
            STEP_S_INVB:  n = STEP_S_DT;
            STEP_S_DT:    n = STEP_KP_S;
            STEP_KP_S:    n = STEP_EPS_SW;
            STEP_EPS_SW:  n = STEP_KI_INT;
            STEP_KI_INT:  n = STEP_FINAL;
            STEP_FINAL:   n = STEP_LAM_ERR;
            default:      n = STEP_LAM_ERR;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/smac_ctrl.sv
`timescale 1ns / 1ps

module smac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output smac_pkg::dp_cmd_t cmd
);

    smac_pkg::state_t state_reg, state_next;
    smac_pkg::step_t  step_reg, step_next;
    logic [1:0]       axis_reg, axis_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // State, step and axis counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smac_pkg::ST_IDLE;
            step_reg     <= smac_pkg::STEP_LAM_ERR;
            axis_reg     <= smac_pkg::AXIS_FIRST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        axis_next     = axis_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.run       = 1'b0;
        cmd.step      = step_reg;
        cmd.axis      = axis_reg;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            smac_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = smac_pkg::STEP_LAM_ERR;
                    axis_next  = smac_pkg::AXIS_FIRST;
                    state_next = smac_pkg::ST_RUN;
                end
            end
            smac_pkg::ST_RUN: begin
                cmd.run   = 1'b1;
                step_next = smac_pkg::step_after(step_reg);
                if (step_reg == smac_pkg::STEP_FINAL) begin
                    if (axis_reg == smac_pkg::AXIS_LAST) begin
                        state_next = smac_pkg::ST_DONE;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
            end
            smac_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = smac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = smac_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/core/smac_datapath.sv
`timescale 1ns / 1ps

module smac_datapath #(
    parameter int GAIN_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  smac_pkg::dp_cmd_t                      cmd,
    input  logic [9*SAMPLE_BITS-1:0]               samples,
    input  logic [3*GAIN_BITS-1:0]                 lambda_gains,
    input  logic [3*GAIN_BITS-1:0]                 switch_gains,
    input  logic [3*GAIN_BITS-1:0]                 proportional_gains,
    input  logic [3*GAIN_BITS-1:0]                 integral_gains,
    input  logic [smac_pkg::DT_BITS-1:0]           step_time,
    input  logic [smac_pkg::INV_BITS-1:0]          inv_boundary,
    input  logic [smac_pkg::LIMIT_BITS-1:0]        integral_limit,
    output logic [3*smac_pkg::DRIVE_BITS-1:0]      drive
);

    localparam int SF  = SAMPLE_BITS - 4;
    localparam int GF  = GAIN_BITS - 8;
    localparam int SW  = SAMPLE_BITS + 9;
    localparam int AW  = (SW > smac_pkg::DRIVE_BITS) ? SW : smac_pkg::DRIVE_BITS;
    localparam int BW  = (GAIN_BITS > smac_pkg::DT_BITS) ? GAIN_BITS : smac_pkg::DT_BITS;
    localparam int PW  = AW + BW + 1;
    localparam int ACW = PW + 2;
    localparam int DW  = smac_pkg::DRIVE_BITS;

    localparam logic signed [PW-1:0]  ONE_P     = PW'(1) << SF;
    localparam logic signed [PW-1:0]  NEG_ONE_P = -ONE_P;
    localparam logic signed [ACW-1:0] DRV_MAX   = ACW'(32'sh7FFF_FFFF);
    localparam logic signed [ACW-1:0] DRV_MIN   = ~DRV_MAX;

    logic signed [SAMPLE_BITS-1:0] err_reg  [smac_pkg::NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] rate_reg [smac_pkg::NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] want_reg [smac_pkg::NUM_AXES];
    logic signed [DW-1:0]          surf_reg [smac_pkg::NUM_AXES];
    logic signed [DW-1:0]          drv_reg  [smac_pkg::NUM_AXES];
    logic signed [PW-1:0]          p_reg;
    logic signed [SW-1:0]          s_reg;
    logic signed [SF+1:0]          sw_reg;
    logic signed [DW-1:0]          integ_reg;
    logic signed [ACW-1:0]         acc_reg;
    logic [3*DW-1:0]               out_reg;

    logic signed [SAMPLE_BITS-1:0] err_a, rate_a, want_a;
    logic signed [SAMPLE_BITS:0]   e_a;
    logic [GAIN_BITS-1:0]          lam_a, eps_a, kp_a, ki_a;
    logic signed [AW-1:0]          mul_a;
    logic [BW-1:0]                 mul_b;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          p_sw, p_dt;
    logic signed [SW-1:0]          s_next;
    logic signed [SF+1:0]          sw_next;
    logic signed [PW:0]            isum, lim_p;
    logic signed [DW-1:0]          integ_next;
    logic signed [ACW-1:0]         fsum, fsh;
    logic signed [DW-1:0]          drv_next;

    // Per-axis operands
    assign err_a  = err_reg[cmd.axis];
    assign rate_a = rate_reg[cmd.axis];
    assign want_a = want_reg[cmd.axis];
    assign e_a    = (SAMPLE_BITS+1)'(want_a) - (SAMPLE_BITS+1)'(rate_a);
    assign lam_a  = lambda_gains[cmd.axis*GAIN_BITS +: GAIN_BITS];
    assign eps_a  = switch_gains[cmd.axis*GAIN_BITS +: GAIN_BITS];
    assign kp_a   = proportional_gains[cmd.axis*GAIN_BITS +: GAIN_BITS];
    assign ki_a   = integral_gains[cmd.axis*GAIN_BITS +: GAIN_BITS];

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            smac_pkg::STEP_LAM_ERR: begin
                mul_a = AW'(err_a);
                mul_b = BW'(lam_a);
            end
            smac_pkg::STEP_LAM_E: begin
                mul_a = AW'(e_a);
                mul_b = BW'(lam_a);
            end
            smac_pkg::STEP_S_INVB: begin
                mul_a = AW'(s_reg);
                mul_b = BW'(inv_boundary);
            end
            smac_pkg::STEP_S_DT: begin
                mul_a = AW'(s_reg);
                mul_b = BW'(step_time);
            end
            smac_pkg::STEP_KP_S: begin
                mul_a = AW'(s_reg);
                mul_b = BW'(kp_a);
            end
            smac_pkg::STEP_EPS_SW: begin
                mul_a = AW'(sw_reg);
                mul_b = BW'(eps_a);
            end
            smac_pkg::STEP_KI_INT: begin
                mul_a = AW'(integ_reg);
                mul_b = BW'(ki_a);
            end
            smac_pkg::STEP_FINAL: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * $signed({1'b0, mul_b});

    // Surface: rate error plus scaled angle error
    assign s_next = SW'(e_a) + SW'(p_reg >>> GF);

    // Boundary-layer switch term, clipped to +/- one
    assign p_sw = p_reg >>> GF;
    always_comb begin
        if (p_sw > ONE_P) begin
            sw_next = (SF+2)'(ONE_P);
        end else if (p_sw < NEG_ONE_P) begin
            sw_next = (SF+2)'(NEG_ONE_P);
        end else begin
            sw_next = (SF+2)'(p_sw);
        end
    end

    // Integral update with symmetric clamp
    assign p_dt  = p_reg >>> smac_pkg::DT_FRAC;
    assign isum  = (PW+1)'(surf_reg[cmd.axis]) + (PW+1)'(p_dt);
    assign lim_p = $signed((PW+1)'(integral_limit));
    always_comb begin
        if (isum > lim_p) begin
            integ_next = DW'(lim_p);
        end else if (isum < -lim_p) begin
            integ_next = DW'(-lim_p);
        end else begin
            integ_next = DW'(isum);
        end
    end

    // Final command: last product added, scaled, saturated to 32 bits
    assign fsum = acc_reg + ACW'(p_reg);
    assign fsh  = fsum >>> GF;
    always_comb begin
        if (fsh > DRV_MAX) begin
            drv_next = DW'(DRV_MAX);
        end else if (fsh < DRV_MIN) begin
            drv_next = DW'(DRV_MIN);
        end else begin
            drv_next = DW'(fsh);
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < smac_pkg::NUM_AXES; i++) begin
                err_reg[i]  <= samples[i*SAMPLE_BITS +: SAMPLE_BITS];
                rate_reg[i] <= samples[(i+3)*SAMPLE_BITS +: SAMPLE_BITS];
                want_reg[i] <= samples[(i+6)*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // Product register and per-axis working registers
    always_ff @(posedge aclk) begin
        if (cmd.run) begin
            p_reg <= prod;
            unique case (cmd.step)
                smac_pkg::STEP_LAM_ERR: begin
                end
                smac_pkg::STEP_LAM_E: begin
                    s_reg <= s_next;
                end
                smac_pkg::STEP_S_INVB: begin
                    acc_reg <= ACW'(p_reg);
                end
                smac_pkg::STEP_S_DT: begin
                    sw_reg <= sw_next;
                end
                smac_pkg::STEP_KP_S: begin
                    integ_reg <= integ_next;
                end
                smac_pkg::STEP_EPS_SW: begin
                    acc_reg <= acc_reg + ACW'(p_reg);
                end
                smac_pkg::STEP_KI_INT: begin
                    acc_reg <= acc_reg + ACW'(p_reg);
                end
                smac_pkg::STEP_FINAL: begin
                    drv_reg[cmd.axis] <= drv_next;
                end
                default: begin
                end
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= {drv_reg[2], drv_reg[1], drv_reg[0]};
        end
    end

    // Surface integrals persist across requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < smac_pkg::NUM_AXES; i++) begin
                surf_reg[i] <= '0;
            end
        end else if (cmd.run && cmd.step == smac_pkg::STEP_KP_S) begin
            surf_reg[cmd.axis] <= integ_next;
        end
    end

    assign drive = out_reg;

endmodule

FILE: rtl/core/three_axis_sliding_mode_attitude_ctrl.sv
`timescale 1ns / 1ps

// Three-axis sliding-mode attitude controller with boundary layer and
// surface integral. A request carries angle error, measured rate and desired
// rate for x, y and z; the result is one saturated 32-bit drive per axis.
// A result is valid once its request has run eight steps per axis on the
// single shared multiplier (one product per cycle, seven products per axis)
// and the output register has been loaded; that load waits while the
// previous result is still held there. The block takes the next request the
// cycle after that load. The next request is accepted once the result has
// moved to the output register, so a result may wait there while the next
// one is computed. Surface integrals clear only on reset. Write configuration
// only while no request is in flight.
module three_axis_sliding_mode_attitude_ctrl #(
    parameter int GAIN_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    // err_x, err_y, err_z, rate_x, rate_y, rate_z, want_rate_x, want_rate_y,
    // want_rate_z; SAMPLE_BITS each, zero padded to whole bytes
    input  logic [((9*SAMPLE_BITS+7)/8)*8-1:0]                s_tdata,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // drive_x, drive_y, drive_z; 32 bits each
    output logic [3*smac_pkg::DRIVE_BITS-1:0]                 m_tdata,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    input  logic                                              cfg_we,
    input  logic [smac_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [((3*GAIN_BITS > 31) ? 3*GAIN_BITS : 31)-1:0] cfg_wdata
);

    logic [3*GAIN_BITS-1:0]              lambda_reg;
    logic [3*GAIN_BITS-1:0]              switch_reg;
    logic [3*GAIN_BITS-1:0]              prop_reg;
    logic [3*GAIN_BITS-1:0]              integral_reg;
    logic [smac_pkg::DT_BITS-1:0]        step_time_reg;
    logic [smac_pkg::INV_BITS-1:0]       inv_bnd_reg;
    logic [smac_pkg::LIMIT_BITS-1:0]     limit_reg;
    smac_pkg::dp_cmd_t                   cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg    <= '0;
            switch_reg    <= '0;
            prop_reg      <= '0;
            integral_reg  <= '0;
            step_time_reg <= smac_pkg::STEP_TIME_RST;
            inv_bnd_reg   <= smac_pkg::INV_BND_RST;
            limit_reg     <= smac_pkg::LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                smac_pkg::REG_LAMBDA:   lambda_reg    <= cfg_wdata[3*GAIN_BITS-1:0];
                smac_pkg::REG_SWITCH:   switch_reg    <= cfg_wdata[3*GAIN_BITS-1:0];
                smac_pkg::REG_PROP:     prop_reg      <= cfg_wdata[3*GAIN_BITS-1:0];
                smac_pkg::REG_INTEGRAL: integral_reg  <= cfg_wdata[3*GAIN_BITS-1:0];
                smac_pkg::REG_STEP:     step_time_reg <= cfg_wdata[smac_pkg::DT_BITS-1:0];
                smac_pkg::REG_INV_BND:  inv_bnd_reg   <= cfg_wdata[smac_pkg::INV_BITS-1:0];
                smac_pkg::REG_LIMIT:    limit_reg     <= cfg_wdata[smac_pkg::LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    smac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    smac_datapath #(
        .GAIN_BITS   (GAIN_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .samples            (s_tdata[9*SAMPLE_BITS-1:0]),
        .lambda_gains       (lambda_reg),
        .switch_gains       (switch_reg),
        .proportional_gains (prop_reg),
        .integral_gains     (integral_reg),
        .step_time          (step_time_reg),
        .inv_boundary       (inv_bnd_reg),
        .integral_limit     (limit_reg),
        .drive              (m_tdata)
    );

    // One request at a time: no new request right after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    // A result appears only out of the wait-for-output phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without a finished computation");

    // Taking a request never disturbs the waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> $stable(m_tdata))
        else $error("output data changed when request was taken");

endmodule
